// ===== sv/r2b_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2b_pkg: shared types and constants of the RGB565 to BMP24 encoder
// Header layout offsets, register indexes, action codes and the channel
// widening functions.
// ----------------------------------------------------------------------------
package r2b_pkg;

  // Field widths
  localparam int unsigned CfgW    = 12;  // image width / height register
  localparam int unsigned CfgIdxW = 2;   // configuration register index
  localparam int unsigned CntW    = 22;  // pixel counter
  localparam int unsigned TotW    = 2 * CfgW;  // width * height
  localparam int unsigned ImgW    = TotW + 2;  // width * height * 3
  localparam int unsigned IdxW    = 6;   // byte position within one transaction

  // Reset values of the registers
  localparam logic [CfgW-1:0] ResetWidth  = 12'd320;
  localparam logic [CfgW-1:0] ResetHeight = 12'd240;

  // Lengths of the two kinds of transaction, in bytes
  localparam logic [IdxW-1:0] HdrLen = 6'd54;
  localparam logic [IdxW-1:0] PxLen  = 6'd3;

  // Header constants
  localparam logic [7:0] MagicB  = 8'h42;
  localparam logic [7:0] MagicM  = 8'h4D;
  localparam logic [7:0] InfoLen = 8'd40;
  localparam logic [7:0] Planes  = 8'd1;
  localparam logic [7:0] Bpp     = 8'd24;

  // Header field offsets
  localparam logic [IdxW-1:0] OffMagic    = 6'd0;
  localparam logic [IdxW-1:0] OffFileSize = 6'd2;
  localparam logic [IdxW-1:0] OffDataOff  = 6'd10;
  localparam logic [IdxW-1:0] OffInfoLen  = 6'd14;
  localparam logic [IdxW-1:0] OffWidth    = 6'd18;
  localparam logic [IdxW-1:0] OffHeight   = 6'd22;
  localparam logic [IdxW-1:0] OffPlanes   = 6'd26;
  localparam logic [IdxW-1:0] OffBpp      = 6'd28;
  localparam logic [IdxW-1:0] OffImgSize  = 6'd34;

  // Pixel byte order
  localparam logic [IdxW-1:0] PxBlue  = 6'd0;
  localparam logic [IdxW-1:0] PxGreen = 6'd1;

  typedef enum logic {
    ActStart = 1'b0,
    ActPixel = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1
  } cfg_idx_e;

  // Frame geometry as the header needs it
  typedef struct packed {
    logic [CfgW-1:0] width;
    logic [31:0]     neg_height;
    logic [ImgW-1:0] img_size;
  } hdr_fields_t;

  // Widen a 5-bit channel: x*255/31 = 8x + floor(7x/31)
  function automatic logic [7:0] scale5(logic [4:0] x);
    logic [2:0] frac;
    if (x >= 5'd31)      frac = 3'd7;
    else if (x >= 5'd27) frac = 3'd6;
    else if (x >= 5'd23) frac = 3'd5;
    else if (x >= 5'd18) frac = 3'd4;
    else if (x >= 5'd14) frac = 3'd3;
    else if (x >= 5'd9)  frac = 3'd2;
    else if (x >= 5'd5)  frac = 3'd1;
    else                 frac = 3'd0;
    return {x, 3'b000} + {5'b00000, frac};
  endfunction

  // Widen a 6-bit channel: x*255/63 = 4x + floor(x/21)
  function automatic logic [7:0] scale6(logic [5:0] x);
    logic [1:0] frac;
    if (x >= 6'd63)      frac = 2'd3;
    else if (x >= 6'd42) frac = 2'd2;
    else if (x >= 6'd21) frac = 2'd1;
    else                 frac = 2'd0;
    return {x, 2'b00} + {6'b000000, frac};
  endfunction

  // Pick byte k of a little-endian 32-bit word
  function automatic logic [7:0] le_byte(logic [31:0] v, logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = v[7:0];
      2'd1:    b = v[15:8];
      2'd2:    b = v[23:16];
      default: b = v[31:24];
    endcase
    return b;
  endfunction

endpackage

// ===== sv/r2b_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2b_if: stream channels of the RGB565 to BMP24 encoder
// Valid/ready channels for input items and for output bytes.
// ----------------------------------------------------------------------------
interface r2b_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] pixel;

  modport source (output valid, action, pixel, input ready);
  modport sink   (input valid, action, pixel, output ready);
endinterface

interface r2b_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

// ===== sv/r2b_byte_sel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2b_byte_sel: byte selector of the BMP24 stream
// Returns the header byte or the widened pixel channel at a byte position.
// ----------------------------------------------------------------------------
module r2b_byte_sel
  import r2b_pkg::*;
(
  input  logic            action_i,
  input  logic [IdxW-1:0] idx_i,
  input  logic [15:0]     pixel_i,
  input  hdr_fields_t     hdr_i,
  output logic [7:0]      byte_o
);

  logic [31:0] file_size;
  logic [31:0] img_size;
  logic [31:0] width_w;

  assign img_size  = 32'(hdr_i.img_size);
  assign file_size = img_size + 32'(HdrLen);
  assign width_w   = 32'(hdr_i.width);

  // Select the byte: B, G, R for a pixel, header bytes otherwise
  always_comb begin
    byte_o = 8'h00;
    if (action_i == ActPixel) begin
      case (idx_i)
        PxBlue:  byte_o = scale5(pixel_i[4:0]);
        PxGreen: byte_o = scale6(pixel_i[10:5]);
        default: byte_o = scale5(pixel_i[15:11]);
      endcase
    end else begin
      case (idx_i)
        OffMagic:             byte_o = MagicB;
        OffMagic + 6'd1:      byte_o = MagicM;
        OffFileSize, OffFileSize + 6'd1, OffFileSize + 6'd2, OffFileSize + 6'd3:
          byte_o = le_byte(file_size, 2'(idx_i - OffFileSize));
        OffDataOff:           byte_o = 8'(HdrLen);
        OffInfoLen:           byte_o = InfoLen;
        OffWidth, OffWidth + 6'd1, OffWidth + 6'd2, OffWidth + 6'd3:
          byte_o = le_byte(width_w, 2'(idx_i - OffWidth));
        OffHeight, OffHeight + 6'd1, OffHeight + 6'd2, OffHeight + 6'd3:
          byte_o = le_byte(hdr_i.neg_height, 2'(idx_i - OffHeight));
        OffPlanes:            byte_o = Planes;
        OffBpp:               byte_o = Bpp;
        OffImgSize, OffImgSize + 6'd1, OffImgSize + 6'd2, OffImgSize + 6'd3:
          byte_o = le_byte(img_size, 2'(idx_i - OffImgSize));
        default:              byte_o = 8'h00;
      endcase
    end
  end

endmodule

// ===== sv/rgb565_to_bmp24_stream_encoder_core.sv =====
`timescale 1ns / 1ps
// Path: each accepted transaction is held in the input register, and its bytes leave
// through the single-byte output register, one byte per cycle while the receiver is
// ready; the next item is taken on the cycle its predecessor's last byte is loaded.
// Reset: asynchronous, active low; clears the pixel count and all valid flags and
// returns the width and height registers to 320 and 240.
// ----------------------------------------------------------------------------
// rgb565_to_bmp24_stream_encoder_core: RGB565 raster to 24-bit BMP stream
// Emits a 54-byte top-down BMP header on a start transaction and three
// widened bytes, B then G then R, on each pixel transaction.
// ----------------------------------------------------------------------------
module rgb565_to_bmp24_stream_encoder_core
  import r2b_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  r2b_in_if.sink             in_if,
  r2b_out_if.source          out_if,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  // Configuration and derived frame size
  logic [CfgW-1:0] width_q, height_q;
  logic [TotW-1:0] prod;
  logic [TotW-1:0] total_q;
  logic [ImgW-1:0] img_q;

  // Input register
  logic            in_valid_q;
  logic            act_q;
  logic [15:0]     pix_q;

  // Sequencing
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] last_idx;
  logic            out_free, emit, is_last, take, fend;

  // Output register
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            run_last_q, frame_end_q;

  hdr_fields_t     hdr;
  logic [7:0]      sel_byte;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgWidth)  width_q  <= cfg_wdata_i;
      if (cfg_idx_i == CfgHeight) height_q <= cfg_wdata_i;
    end
  end

  // Derive pixel total and image size
  assign prod = TotW'(width_q) * TotW'(height_q);

  always_ff @(posedge clk_i) begin
    total_q <= prod;
    img_q   <= {prod, 1'b0} + ImgW'(prod);
  end

  assign hdr.width      = width_q;
  assign hdr.neg_height = 32'd0 - 32'(height_q);
  assign hdr.img_size   = img_q;

  // Handshake and byte sequencing
  assign out_free  = !out_valid_q || out_if.ready;
  assign emit      = in_valid_q && out_free;
  assign last_idx  = (act_q == ActPixel) ? (PxLen - 6'd1) : (HdrLen - 6'd1);
  assign is_last   = (idx_q == last_idx);
  assign take      = emit && is_last;
  assign in_if.ready = !in_valid_q || take;

  // Flag the last pixel of the frame
  assign fend = (act_q == ActPixel) && (total_q != '0) &&
                ({2'b00, cnt_q} == (total_q - TotW'(1)));

  always_comb begin
    idx_d = idx_q;
    cnt_d = cnt_q;
    if (emit) begin
      idx_d = is_last ? '0 : idx_q + 6'd1;
    end
    if (take) begin
      if (act_q == ActStart || fend) cnt_d = '0;
      else                           cnt_d = cnt_q + CntW'(1);
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      idx_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (in_if.ready) in_valid_q <= in_if.valid;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      act_q <= in_if.action;
      pix_q <= in_if.pixel;
    end
  end

  r2b_byte_sel u_byte_sel (
    .action_i (act_q),
    .idx_i    (idx_q),
    .pixel_i  (pix_q),
    .hdr_i    (hdr),
    .byte_o   (sel_byte)
  );

  // Advance the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= sel_byte;
      run_last_q  <= is_last;
      frame_end_q <= is_last && fend;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_byte  = out_byte_q;
  assign out_if.run_last  = run_last_q;
  assign out_if.frame_end = frame_end_q;

endmodule

// ===== sv/r2b_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2b_checker: port-level checks of the BMP24 stream encoder
// Watches the output channel for stall, reset and frame-end rules.
// ----------------------------------------------------------------------------
module r2b_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       run_last_i,
  input logic       frame_end_i
);

  // Hold a stalled transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
                                    $stable(run_last_i) && $stable(frame_end_i))
    else $error("output transaction changed while stalled");

  // Frame end only on the closing byte of a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> run_last_i)
    else $error("frame_end without run_last");

  // No output during reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // An accepted frame-end byte is never directly followed by another frame-end byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && frame_end_i |=> !(out_valid_i && frame_end_i))
    else $error("two frame_end bytes in a row");

endmodule

bind rgb565_to_bmp24_stream_encoder_core r2b_checker u_r2b_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_byte_i  (out_if.out_byte),
  .run_last_i  (out_if.run_last),
  .frame_end_i (out_if.frame_end)
);

// ===== tb/sv/rgb565_to_bmp24_stream_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_to_bmp24_stream_encoder_core_tb: self-checking bench of the encoder
// Drives start and pixel transactions under random sender gaps and receiver
// stalls. A local model builds the 54-byte BMP header and the widened B, G, R
// bytes, tracks the pixel count and frame end, and every output byte is
// compared field by field in order.
// ----------------------------------------------------------------------------
module rgb565_to_bmp24_stream_encoder_core_tb;
  import r2b_pkg::*;

  localparam int unsigned HdrBytes      = 54;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned RandomItems   = 72;

  // No register sits behind this index; writes to it must change nothing
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  typedef struct {
    logic [7:0] value;
    logic       run_last;
    logic       frame_end;
  } bmp_byte_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;

  r2b_in_if  in_ch ();
  r2b_out_if out_ch ();

  rgb565_to_bmp24_stream_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Model state: geometry registers and pixel count
  logic [CfgW-1:0] mdl_width  = 12'd320;
  logic [CfgW-1:0] mdl_height = 12'd240;
  logic [CntW-1:0] px_count   = '0;

  bmp_byte_t   bmp_byte_q[$];
  int unsigned mismatches  = 0;
  int unsigned burst_left  = 0;
  bit          steady_send = 1'b0;
  bit          hold_req    = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Widen an n-bit channel to 8 bits with truncating division
  function automatic logic [7:0] widen(int unsigned raw, int unsigned top);
    return 8'((raw * 255) / top);
  endfunction

  // Append the bytes one transaction must produce and advance the pixel count
  function automatic void encode_item(action_e act, logic [15:0] px);
    logic [31:0] total;
    logic [31:0] img;
    logic [31:0] fsize;
    logic [31:0] neg_h;
    logic [31:0] wid;
    logic [7:0]  hdr [HdrBytes];
    logic        fend;
    bmp_byte_t   b;
    total = 32'(mdl_width) * 32'(mdl_height);
    if (act == ActStart) begin
      img   = total * 32'd3;
      fsize = img + 32'(HdrBytes);
      neg_h = 32'd0 - 32'(mdl_height);
      wid   = 32'(mdl_width);
      foreach (hdr[i]) hdr[i] = 8'h00;
      hdr[0]  = 8'h42;
      hdr[1]  = 8'h4D;
      hdr[10] = 8'(HdrBytes);
      hdr[14] = 8'd40;
      hdr[26] = 8'd1;
      hdr[28] = 8'd24;
      for (int k = 0; k < 4; k++) begin
        hdr[2 + k]  = fsize[8*k +: 8];
        hdr[18 + k] = wid[8*k +: 8];
        hdr[22 + k] = neg_h[8*k +: 8];
        hdr[34 + k] = img[8*k +: 8];
      end
      px_count = '0;
      for (int i = 0; i < HdrBytes; i++) begin
        b.value     = hdr[i];
        b.run_last  = (i == HdrBytes - 1);
        b.frame_end = 1'b0;
        bmp_byte_q.push_back(b);
      end
    end else begin
      fend     = (total != 32'd0) && (32'(px_count) == total - 32'd1);
      px_count = fend ? '0 : px_count + 1'b1;
      b.run_last  = 1'b0;
      b.frame_end = 1'b0;
      b.value     = widen(px[4:0], 31);
      bmp_byte_q.push_back(b);
      b.value     = widen(px[10:5], 63);
      bmp_byte_q.push_back(b);
      b.value     = widen(px[15:11], 31);
      b.run_last  = 1'b1;
      b.frame_end = fend;
      bmp_byte_q.push_back(b);
    end
  endfunction

  // Predict on accepted input, compare each accepted output byte
  always @(negedge clk_i) begin : byte_check
    bmp_byte_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        encode_item(action_e'(in_ch.action), in_ch.pixel);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (bmp_byte_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("[%0t] unexpected byte %02h last %0b frame_end %0b", $realtime,
                     out_ch.out_byte, out_ch.run_last, out_ch.frame_end);
          end
        end else begin
          want = bmp_byte_q.pop_front();
          if (out_ch.out_byte !== want.value || out_ch.run_last !== want.run_last ||
              out_ch.frame_end !== want.frame_end) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("[%0t] byte mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                       $realtime, want.value, want.run_last, want.frame_end,
                       out_ch.out_byte, out_ch.run_last, out_ch.frame_end);
            end
          end
        end
      end
    end
  end

  // Abort when no transaction moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchdogLimit) begin
      @(negedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("rgb565_to_bmp24_stream_encoder_core_tb NOT OK");
    $finish;
  end

  // Receiver: a random stall pattern, redrawn whenever its run ends, plus long holds
  initial begin : byte_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= (mode_left % 4 != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offer one transaction and hold it until accepted; insert gaps between bursts
  task automatic send_item(input action_e act, input logic [15:0] px);
    int unsigned gap;
    logic        taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 && !steady_send) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.pixel  <= px;
    do begin
      @(negedge clk_i);
      taken = in_ch.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_start();
    send_item(ActStart, 16'($urandom_range(0, 65535)));
  endtask

  task automatic send_pixel(input logic [15:0] px);
    send_item(ActPixel, px);
  endtask

  // Stop offering and wait until every expected byte has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (bmp_byte_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CfgWidth:  mdl_width  = val;
      CfgHeight: mdl_height = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    drain();
    write_reg(CfgWidth, w);
    write_reg(CfgHeight, h);
  endtask

  // Reset geometry header and the corner colors
  task automatic test_reset_geometry();
    send_start();
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'hF800);
    send_pixel(16'h07E0);
    send_pixel(16'h001F);
    send_pixel(16'hAAAA);
  endtask

  // Frames of one and two pixels; later frames run on without a start
  task automatic test_tiny_frames();
    set_geometry(12'd1, 12'd1);
    send_start();
    send_pixel(16'h5555);
    send_pixel(16'($urandom_range(0, 65535)));
    set_geometry(12'd2, 12'd1);
    send_start();
    repeat (4) send_pixel(16'($urandom_range(0, 65535)));
  endtask

  // Oversized frame, zero width, and a write to an unused index
  task automatic test_size_extremes();
    set_geometry(12'hFFF, 12'hFFF);
    send_start();
    send_pixel(16'($urandom_range(0, 65535)));
    set_geometry(12'd0, 12'd5);
    send_start();
    send_pixel(16'($urandom_range(0, 65535)));
    set_geometry(12'd2048, 12'd2048);
    write_reg(CfgSpare, 12'($urandom_range(0, 4095)));
    send_start();
  endtask

  // Shrink the frame while it is in progress so the next pixel closes it
  task automatic test_resize_mid_frame();
    set_geometry(12'd4, 12'd1);
    send_start();
    send_pixel(16'($urandom_range(0, 65535)));
    drain();
    write_reg(CfgWidth, 12'd2);
    send_pixel(16'($urandom_range(0, 65535)));
  endtask

  // Hold the output off while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    set_geometry(12'd2, 12'd2);
    send_start();
    steady_send = 1'b1;
    hold_req    = 1'b1;
    repeat (24) send_pixel(16'($urandom_range(0, 65535)));
    steady_send = 1'b0;
    drain();
  endtask

  // Random geometries, mostly whole frames, with stray starts and headless runs
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned phase;
    logic [CfgW-1:0] w;
    logic [CfgW-1:0] h;
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      if (phase % 6 == 5) begin
        w = 12'($urandom_range(1, 4095));
        h = 12'($urandom_range(1, 4095));
      end else if (phase == 2) begin
        w = 12'hFFF;
        h = 12'd1;
      end else begin
        w = 12'($urandom_range(1, 4));
        h = 12'($urandom_range(1, 3));
      end
      set_geometry(w, h);
      if ($urandom_range(0, 4) != 0) begin
        send_start();
        sent++;
      end
      n = (32'(w) * 32'(h) <= 12) ? 32'(w) * 32'(h) * $urandom_range(1, 2)
                                  : $urandom_range(2, 8);
      repeat (n) begin
        if ($urandom_range(0, 15) == 0) send_start();
        else send_pixel(16'($urandom_range(0, 65535)));
      end
      sent += n;
      phase++;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgWidth;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.action = ActStart;
    in_ch.pixel  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_geometry();
    test_tiny_frames();
    test_size_extremes();
    test_resize_mid_frame();
    test_backpressure();
    test_random_frames();

    // Let the last bytes out, then allow the pipeline to settle
    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && bmp_byte_q.size() == 0) begin
      $display("rgb565_to_bmp24_stream_encoder_core_tb OK");
    end else begin
      $display("rgb565_to_bmp24_stream_encoder_core_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/r2b_pkg.sv
sv/r2b_if.sv
sv/r2b_byte_sel.sv
sv/rgb565_to_bmp24_stream_encoder_core.sv
sv/r2b_checker.sv
tb/sv/rgb565_to_bmp24_stream_encoder_core_tb.sv
